// ===== hdl/calendar_date_stepper_defines.svh =====
// Assertion macros used by the checker file of the date stepper.
// Each macro samples on clk and is disabled while rst is high.
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH

// Same-cycle implication.
`define CDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cds_pkg.sv =====
// Package for the calendar date stepper: field widths, command codes,
// calendar tables and small calendar functions. No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 3;
  localparam int WD_W    = 3;
  localparam int DOY_W   = 9;
  localparam int TDATA_W = 40;

  // shared multiplier operand widths
  localparam int MUL_A_W = 14;
  localparam int MUL_B_W = 15;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PREV = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;

  localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd1970;

  // floor(y/100) = (y * 5243) >> 19 for y < 16384
  localparam logic [MUL_B_W-1:0] RECIP_100 = 15'd5243;
  localparam int                 SHIFT_100 = 19;
  // floor(s/7) = (s * 18725) >> 17 for s < 16384
  localparam logic [MUL_B_W-1:0] RECIP_7   = 15'd18725;
  localparam int                 SHIFT_7   = 17;

  // leap test on the century split of a year (y = hi*100 + lo)
  function automatic logic is_leap(input logic [6:0] lo, input logic [6:0] hi);
    return (lo == 7'd0) ? (hi[1:0] == 2'd0) : (lo[1:0] == 2'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic lp);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                      r = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // (13*m + 8)/5 with Jan/Feb counted as months 13 and 14
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] r;
    unique case (m)
      4'd1:    r = 6'd35;
      4'd2:    r = 6'd38;
      4'd3:    r = 6'd9;
      4'd4:    r = 6'd12;
      4'd5:    r = 6'd14;
      4'd6:    r = 6'd17;
      4'd7:    r = 6'd19;
      4'd8:    r = 6'd22;
      4'd9:    r = 6'd25;
      4'd10:   r = 6'd27;
      4'd11:   r = 6'd30;
      4'd12:   r = 6'd32;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cds_mul.sv =====
// Shared registered multiplier of the date stepper.
// Depends on cds_pkg for operand widths.
`timescale 1ns / 1ps

module cds_mul (
  input  logic                        clk,
  input  logic [cds_pkg::MUL_A_W-1:0] a,
  input  logic [cds_pkg::MUL_B_W-1:0] b,
  output logic [cds_pkg::MUL_P_W-1:0] p
);
  import cds_pkg::*;

  always_ff @(posedge clk) begin
    p <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

endmodule

// ===== hdl/calendar_date_stepper.sv =====
// Gregorian date stepper: holds one date and applies one command per input
// transfer. Depends on cds_pkg and cds_mul.
//
// Input channel s_*: s_tuser carries the command (load, next day, previous
// day, add days, subtract days); s_tdata carries the load date and the day
// count. Output channel m_*: one transfer per command with the date held
// afterwards, its weekday (0 = Sunday), its day of year, and in m_tuser the
// error flag for a rejected load or a step that would leave years 1..9999.
// A rejected command leaves the date as it was.
//
// Timing: a small sequencer walks the date one month per cycle and then
// finishes weekday and day-of-year in states WK1 to WK4 around a single
// shared multiplier (reciprocal divisions by 100 and by 7). An unused
// command goes straight to those states, a load first passes the split and
// check states, and a step first walks the months that it crosses.
// s_tready is high only while idle: one command at a time, the next taken no
// sooner than the edge after its predecessor's result appears. A held result
// does not block the next command, which runs and waits for the register.
// Reset (rst, synchronous) sets the date to 1970-01-01 and drops m_tvalid.
`timescale 1ns / 1ps

module calendar_date_stepper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [13:0] year_in, [17:14] month_in, [22:18] day_in, [38:23] day_count
  input  logic [cds_pkg::TDATA_W-1:0] s_tdata,
  // [2:0] mode
  input  logic [cds_pkg::MODE_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [25:23] weekday,
  // [34:26] day_of_year
  output logic [cds_pkg::TDATA_W-1:0] m_tdata,
  // [0] range_error
  output logic [0:0]                  m_tuser
);
  import cds_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LD_SPLIT = 4'd1;
  localparam logic [3:0] ST_LD_CHK   = 4'd2;
  localparam logic [3:0] ST_FWD      = 4'd3;
  localparam logic [3:0] ST_BACK     = 4'd4;
  localparam logic [3:0] ST_WK1      = 4'd5;
  localparam logic [3:0] ST_WK2      = 4'd6;
  localparam logic [3:0] ST_WK3      = 4'd7;
  localparam logic [3:0] ST_WK4      = 4'd8;

  logic [3:0] state;

  // held date, with the year also kept split as hi*100 + lo
  logic [YEAR_W-1:0]  cur_year;
  logic [6:0]         cur_hi, cur_lo;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;

  // captured load fields
  logic [YEAR_W-1:0]  ld_year;
  logic [MONTH_W-1:0] ld_month;
  logic [DAY_W-1:0]   ld_day;

  // working date for the month walk
  logic [YEAR_W-1:0]  w_year;
  logic [6:0]         w_hi, w_lo;
  logic [MONTH_W-1:0] w_month;
  logic signed [17:0] dd;
  logic               err;

  // weekday / ordinal pipeline
  logic [6:0]       wk_c;
  logic [14:0]      wk_part;
  logic [13:0]      wk_sum;
  logic [DOY_W-1:0] wk_doy;

  // output register
  logic [YEAR_W-1:0]  o_year;
  logic [MONTH_W-1:0] o_month;
  logic [DAY_W-1:0]   o_day;
  logic [WD_W-1:0]    o_wd;
  logic [DOY_W-1:0]   o_doy;
  logic               o_err;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // input fields
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [COUNT_W-1:0] in_count;

  logic accept, out_free;

  assign in_year  = s_tdata[13:0];
  assign in_month = s_tdata[17:14];
  assign in_day   = s_tdata[22:18];
  assign in_count = s_tdata[38:23];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // idle: year / 100 for a load; otherwise the weekday sum / 7
  assign mul_a = (state == ST_IDLE) ? in_year : wk_sum;
  assign mul_b = (state == ST_IDLE) ? RECIP_100 : RECIP_7;

  cds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // starting day offset for the walk
  logic [16:0]        step_n;
  logic [17:0]        d18, n18;
  logic signed [17:0] dd_fwd, dd_back;

  always_comb begin
    step_n  = ((s_tuser == MODE_ADD) || (s_tuser == MODE_SUB)) ? {1'b0, in_count} : 17'd1;
    d18     = {13'd0, cur_day};
    n18     = {1'b0, step_n};
    dd_fwd  = $signed(d18 + n18);
    dd_back = $signed(d18 - n18);
  end

  // load split and check
  logic [6:0]        ld_hi, ld_lo;
  logic [YEAR_W-1:0] ld_hi100, ld_rem;
  logic              ld_ok;

  always_comb begin
    ld_hi    = mul_p[SHIFT_100+6:SHIFT_100];
    ld_hi100 = YEAR_W'({ld_hi, 6'd0}) + YEAR_W'({ld_hi, 5'd0}) + YEAR_W'({ld_hi, 2'd0});
    ld_rem   = ld_year - ld_hi100;
    ld_lo    = ld_rem[6:0];
    ld_ok    = (ld_year >= YEAR_MIN) && (ld_year <= YEAR_MAX) &&
               (ld_month >= 4'd1) && (ld_month <= 4'd12) && (ld_day != 5'd0) &&
               (ld_day <= month_days(ld_month, is_leap(w_lo, w_hi)));
  end

  // month walk
  logic               w_leap;
  logic [DAY_W-1:0]   w_dim, prev_dim;
  logic [MONTH_W-1:0] prev_month;
  logic               dd_over, dd_under, fwd_fail, back_fail;

  always_comb begin
    w_leap     = is_leap(w_lo, w_hi);
    w_dim      = month_days(w_month, w_leap);
    prev_month = w_month - 4'd1;
    prev_dim   = month_days(prev_month, w_leap);
    dd_over    = dd > $signed({13'd0, w_dim});
    dd_under   = dd < 18'sd1;
    fwd_fail   = (w_month == 4'd12) && (w_year == YEAR_MAX);
    back_fail  = (w_month == 4'd1) && (w_year == YEAR_MIN);
  end

  // weekday terms: Jan/Feb belong to the previous year
  logic              early;
  logic [YEAR_W-1:0] wy;
  logic [6:0]        wc;
  logic [14:0]       part, sum15;
  logic [DOY_W-1:0]  doy;
  logic [11:0]       q7;
  logic [14:0]       q7x7, rem7;

  always_comb begin
    early = (cur_month == 4'd1) || (cur_month == 4'd2);
    wy    = early ? cur_year - 14'd1 : cur_year;
    wc    = (early && (cur_lo == 7'd0)) ? cur_hi - 7'd1 : cur_hi;
    part  = {1'b0, wy} + {3'd0, wy[13:2]} - {8'd0, wc};
    doy   = cum_days(cur_month) + {4'd0, cur_day} +
            {8'd0, (!early && is_leap(cur_lo, cur_hi))};
    sum15 = wk_part + {10'd0, wk_c[6:2]} + {9'd0, month_term(cur_month)} +
            {10'd0, cur_day};
    q7    = mul_p[SHIFT_7+11:SHIFT_7];
    q7x7  = {q7, 3'd0} - {3'd0, q7};
    rem7  = {1'b0, wk_sum} - q7x7;
  end

  // sequencer and held date
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_year  <= YEAR_RESET;
      cur_hi    <= 7'd19;
      cur_lo    <= 7'd70;
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
      m_tvalid  <= 1'b0;
    end else begin
      // a result loaded in ST_WK4 takes over the register in the same cycle
      if (m_tvalid && m_tready && (state != ST_WK4)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority case (s_tuser)
              MODE_LOAD:           state <= ST_LD_SPLIT;
              MODE_NEXT, MODE_ADD: state <= ST_FWD;
              MODE_PREV, MODE_SUB: state <= ST_BACK;
              default:             state <= ST_WK1;
            endcase
          end
        end
        ST_LD_SPLIT: state <= ST_LD_CHK;
        ST_LD_CHK: begin
          if (ld_ok) begin
            cur_year  <= ld_year;
            cur_hi    <= w_hi;
            cur_lo    <= w_lo;
            cur_month <= ld_month;
            cur_day   <= ld_day;
          end
          state <= ST_WK1;
        end
        ST_FWD: begin
          if (dd_over) begin
            if (fwd_fail) begin
              state <= ST_WK1;
            end
          end else begin
            cur_year  <= w_year;
            cur_hi    <= w_hi;
            cur_lo    <= w_lo;
            cur_month <= w_month;
            cur_day   <= dd[4:0];
            state     <= ST_WK1;
          end
        end
        ST_BACK: begin
          if (dd_under) begin
            if (back_fail) begin
              state <= ST_WK1;
            end
          end else begin
            cur_year  <= w_year;
            cur_hi    <= w_hi;
            cur_lo    <= w_lo;
            cur_month <= w_month;
            cur_day   <= dd[4:0];
            state     <= ST_WK1;
          end
        end
        ST_WK1: state <= ST_WK2;
        ST_WK2: state <= ST_WK3;
        ST_WK3: state <= ST_WK4;
        ST_WK4: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ld_year  <= in_year;
          ld_month <= in_month;
          ld_day   <= in_day;
          w_year   <= cur_year;
          w_hi     <= cur_hi;
          w_lo     <= cur_lo;
          w_month  <= cur_month;
          err      <= 1'b0;
          dd       <= ((s_tuser == MODE_PREV) || (s_tuser == MODE_SUB)) ? dd_back : dd_fwd;
        end
      end
      ST_LD_SPLIT: begin
        w_hi <= ld_hi;
        w_lo <= ld_lo;
      end
      ST_LD_CHK: err <= !ld_ok;
      ST_FWD: begin
        if (dd_over) begin
          if (fwd_fail) begin
            err <= 1'b1;
          end else begin
            dd <= dd - $signed({13'd0, w_dim});
            if (w_month == 4'd12) begin
              w_month <= 4'd1;
              w_year  <= w_year + 14'd1;
              if (w_lo == 7'd99) begin
                w_lo <= 7'd0;
                w_hi <= w_hi + 7'd1;
              end else begin
                w_lo <= w_lo + 7'd1;
              end
            end else begin
              w_month <= w_month + 4'd1;
            end
          end
        end
      end
      ST_BACK: begin
        if (dd_under) begin
          if (back_fail) begin
            err <= 1'b1;
          end else if (w_month == 4'd1) begin
            // into December of the previous year
            w_month <= 4'd12;
            w_year  <= w_year - 14'd1;
            dd      <= dd + 18'sd31;
            if (w_lo == 7'd0) begin
              w_lo <= 7'd99;
              w_hi <= w_hi - 7'd1;
            end else begin
              w_lo <= w_lo - 7'd1;
            end
          end else begin
            w_month <= prev_month;
            dd      <= dd + $signed({13'd0, prev_dim});
          end
        end
      end
      ST_WK1: begin
        wk_c    <= wc;
        wk_part <= part;
        wk_doy  <= doy;
      end
      ST_WK2: wk_sum <= sum15[13:0];
      ST_WK3: ;
      ST_WK4: begin
        if (out_free) begin
          o_year  <= cur_year;
          o_month <= cur_month;
          o_day   <= cur_day;
          o_wd    <= rem7[2:0];
          o_doy   <= wk_doy;
          o_err   <= err;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {5'd0, o_doy, o_wd, o_day, o_month, o_year};
  assign m_tuser = o_err;

endmodule

// ===== hdl/cds_checker.sv =====
// Port-level checker for the calendar date stepper, bound to the top level.
// Depends on calendar_date_stepper_defines.svh.
`timescale 1ns / 1ps
`include "calendar_date_stepper_defines.svh"

module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic [3:0] mon;
  logic [4:0] dom;
  logic [2:0] wd;
  logic [8:0] doy;

  assign mon = m_tdata[17:14];
  assign dom = m_tdata[22:18];
  assign wd  = m_tdata[25:23];
  assign doy = m_tdata[34:26];

  `CDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `CDS_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "command taken while busy")
  `CDS_ASSERT_NOW(a_date_sane, m_tvalid, mon >= 4'd1 && mon <= 4'd12 && dom >= 5'd1 && wd <= 3'd6 && doy >= 9'd1 && doy <= 9'd366, "reported date out of range")
  `CDS_ASSERT_NOW(a_january_ordinal, m_tvalid && mon == 4'd1, doy == {4'd0, dom}, "January ordinal mismatch")

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
